>>> rtl/u8u16_pkg.sv
// shared types and constants for the utf-8 to utf-16le transcoder
// no dependencies
package u8u16_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;

  localparam int MAX_ITEMS = 4;

  localparam logic [7:0]  BOM_FIRST  = 8'hFF;
  localparam logic [7:0]  BOM_SECOND = 8'hFE;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [15:0] LO_SURR    = 16'hDC00;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } item_t;

  // up to four result items produced by one input byte
  typedef struct packed {
    item_t [MAX_ITEMS-1:0] items;
    logic [1:0]            last_idx;
  } entry_t;

endpackage

>>> rtl/u8u16_in_if.sv
// input byte channel: valid/ready plus one utf-8 byte and end marker
// no dependencies
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, in_byte, last_byte, input ready);
  modport sink (input valid, in_byte, last_byte, output ready);
endinterface

>>> rtl/u8u16_out_if.sv
// result channel: valid/ready plus one utf-16le byte, status and end marker
// no dependencies
interface u8u16_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       string_end;

  modport source (output valid, out_byte, status, string_end, input ready);
  modport sink (input valid, out_byte, status, string_end, output ready);
endinterface

>>> rtl/u8u16_cfg_if.sv
// configuration write channel for the emit_bom register
// no dependencies
interface u8u16_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/u8u16_front.sv
// front end: accepts utf-8 bytes, tracks sequence state, builds result entries
// depends on u8u16_pkg and u8u16_in_if
module u8u16_front (
  input  logic               clk,
  input  logic               rst,
  u8u16_in_if.sink           utf8,
  input  logic               emit_bom,
  input  logic               full,
  output logic               push,
  output u8u16_pkg::entry_t  entry
);

  logic [1:0]  bytes_pending;
  logic [20:0] code_accum;
  logic        at_string_start;
  logic        discarding;

  logic [1:0]  bytes_pending_next;
  logic [20:0] code_accum_next;
  logic        discarding_next;

  logic        accept;
  logic [7:0]  b;
  logic [1:0]  lead_len;
  logic        code_emit;
  logic        bad_emit;
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic [15:0] hi_unit;
  logic [15:0] lo_unit;
  logic [2:0]  n;
  logic [2:0]  n_cap;
  u8u16_pkg::item_t cand [0:7];

  assign accept     = utf8.valid && !full;
  assign utf8.ready = !full;
  assign b          = utf8.in_byte;

  always_comb begin
    priority if (b[5:0] < 6'd32) begin
      lead_len = 2'd1;
    end else if (b[5:0] < 6'd48) begin
      lead_len = 2'd2;
    end else if (b[5:0] < 6'd56) begin
      lead_len = 2'd3;
    end else begin
      lead_len = 2'd0;
    end
  end

  // sequence state
  always_comb begin
    bytes_pending_next = bytes_pending;
    code_accum_next    = code_accum;
    discarding_next    = discarding;
    code_emit          = 1'b0;
    bad_emit           = 1'b0;
    cp                 = '0;
    priority if (discarding) begin
      code_emit = 1'b0;
    end else if (bytes_pending != 2'd0) begin
      code_accum_next    = {code_accum[14:0], b[5:0]};
      bytes_pending_next = bytes_pending - 2'd1;
      code_emit          = (bytes_pending == 2'd1);
      cp                 = code_accum_next;
    end else if (!b[7]) begin
      code_emit = 1'b1;
      cp        = {13'd0, b};
    end else if (lead_len == 2'd0) begin
      bad_emit        = 1'b1;
      discarding_next = 1'b1;
    end else begin
      bytes_pending_next = lead_len;
      unique case (lead_len)
        2'd1:    code_accum_next = {16'd0, b[4:0]};
        2'd2:    code_accum_next = {17'd0, b[3:0]};
        default: code_accum_next = {18'd0, b[2:0]};
      endcase
    end
  end

  assign cp_off  = cp - u8u16_pkg::SUPP_BASE;
  assign hi_unit = {5'd0, cp_off[20:10]} | u8u16_pkg::HI_SURR;
  assign lo_unit = {6'd0, cp_off[9:0]} | u8u16_pkg::LO_SURR;

  // item list for this byte, capped at four
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cand[i] = '0;
    end
    n = 3'd0;
    if (at_string_start && emit_bom) begin
      cand[0] = '{data: u8u16_pkg::BOM_FIRST, status: u8u16_pkg::ST_OK, last: 1'b0};
      cand[1] = '{data: u8u16_pkg::BOM_SECOND, status: u8u16_pkg::ST_OK, last: 1'b0};
      n = 3'd2;
    end
    if (bad_emit) begin
      cand[n] = '{data: 8'd0, status: u8u16_pkg::ST_BAD_LEAD, last: 1'b1};
      n = n + 3'd1;
    end
    if (code_emit) begin
      if (cp[20:16] == 5'd0) begin
        cand[n]        = '{data: cp[7:0], status: u8u16_pkg::ST_OK, last: 1'b0};
        cand[n + 3'd1] = '{data: cp[15:8], status: u8u16_pkg::ST_OK, last: 1'b0};
        n = n + 3'd2;
      end else begin
        cand[n]        = '{data: hi_unit[7:0], status: u8u16_pkg::ST_OK, last: 1'b0};
        cand[n + 3'd1] = '{data: hi_unit[15:8], status: u8u16_pkg::ST_OK, last: 1'b0};
        cand[n + 3'd2] = '{data: lo_unit[7:0], status: u8u16_pkg::ST_OK, last: 1'b0};
        cand[n + 3'd3] = '{data: lo_unit[15:8], status: u8u16_pkg::ST_OK, last: 1'b0};
        n = n + 3'd4;
      end
    end
    if (utf8.last_byte && !discarding_next && bytes_pending_next != 2'd0) begin
      cand[n] = '{data: 8'd0, status: u8u16_pkg::ST_TRUNC, last: 1'b1};
      n = n + 3'd1;
    end
    n_cap = (n > 3'd4) ? 3'd4 : n;
    entry.last_idx = 2'(n_cap - 3'd1);
    if (utf8.last_byte && n != 3'd0) begin
      cand[{1'b0, entry.last_idx}].last = 1'b1;
    end
    for (int i = 0; i < u8u16_pkg::MAX_ITEMS; i++) begin
      entry.items[i] = cand[i];
    end
  end

  assign push = accept && (n != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending   <= '0;
      code_accum      <= '0;
      at_string_start <= 1'b1;
      discarding      <= 1'b0;
    end else if (accept) begin
      if (utf8.last_byte) begin
        bytes_pending   <= '0;
        code_accum      <= '0;
        at_string_start <= 1'b1;
        discarding      <= 1'b0;
      end else begin
        bytes_pending   <= bytes_pending_next;
        code_accum      <= code_accum_next;
        at_string_start <= 1'b0;
        discarding      <= discarding_next;
      end
    end
  end

endmodule

>>> rtl/u8u16_queue.sv
// short entry queue between front and back ends
// depends on u8u16_pkg
module u8u16_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  u8u16_pkg::entry_t  push_entry,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output u8u16_pkg::entry_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u8u16_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/u8u16_back.sv
// back end: walks queued entries and sends one result byte per transfer
// depends on u8u16_pkg and u8u16_out_if
module u8u16_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               not_empty,
  input  u8u16_pkg::entry_t  head,
  output logic               pop,
  u8u16_out_if.source        utf16
);

  logic [1:0]       idx;
  logic             load;
  u8u16_pkg::item_t cur;

  assign load = not_empty && (!utf16.valid || utf16.ready);
  assign cur  = head.items[idx];
  assign pop  = load && (idx == head.last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      utf16.valid <= 1'b0;
    end else begin
      if (load) begin
        idx         <= pop ? 2'd0 : idx + 2'd1;
        utf16.valid <= 1'b1;
      end else if (utf16.ready) begin
        utf16.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      utf16.out_byte   <= cur.data;
      utf16.status     <= cur.status;
      utf16.string_end <= cur.last;
    end
  end

endmodule

>>> rtl/utf8_to_utf16le_transcoder.sv
// top level of the utf-8 to utf-16le transcoder
// depends on u8u16_pkg, the channel interfaces, u8u16_front, u8u16_queue, u8u16_back
// path: an accepted input byte's entry is written into the entry queue, then its result bytes into the output register
// throughput: one result byte per cycle from the output register while the receiver is ready; an input byte
//   is taken every cycle while the entry queue has room
// reset: synchronous, clears sequence state and queue, sets emit_bom to 1
module utf8_to_utf16le_transcoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  u8u16_in_if.sink     utf8,
  u8u16_out_if.source  utf16,
  u8u16_cfg_if.sink    cfg
);

  logic              emit_bom;
  logic              push;
  logic              pop;
  logic              full;
  logic              not_empty;
  u8u16_pkg::entry_t push_entry;
  u8u16_pkg::entry_t head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_bom <= 1'b1;
    end else if (cfg.valid) begin
      emit_bom <= cfg.data;
    end
  end

  u8u16_front u_front (
    .clk      (clk),
    .rst      (rst),
    .utf8     (utf8),
    .emit_bom (emit_bom),
    .full     (full),
    .push     (push),
    .entry    (push_entry)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .utf16     (utf16)
  );

endmodule

>>> sim/utf8_to_utf16le_transcoder_tb.sv
// testbench for utf8_to_utf16le_transcoder: byte strings in, utf-16le bytes out, checked
// against an in-bench transcoder under random idling, a long output stall and both bom settings
// depends on u8u16_pkg, u8u16_in_if, u8u16_out_if, u8u16_cfg_if and the rtl top level
`timescale 1ns / 1ps

module utf8_to_utf16le_transcoder_tb;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } utf8_byte_t;

  logic clk;
  logic rst;

  u8u16_in_if  utf8_ch ();
  u8u16_out_if utf16_ch ();
  u8u16_cfg_if cfg_ch ();

  utf8_to_utf16le_transcoder u_dut (
    .clk   (clk),
    .rst   (rst),
    .utf8  (utf8_ch),
    .utf16 (utf16_ch),
    .cfg   (cfg_ch)
  );

  utf8_byte_t        utf8_q[$];
  u8u16_pkg::item_t  pending_utf16[$];
  u8u16_pkg::item_t  step_items[$];

  // transcoder state mirrored in the bench
  logic        bom_on;
  logic [1:0]  cont_left;
  logic [20:0] code_pt;
  logic        string_fresh;
  logic        skip_rest;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          accepted_cnt;
  int          hold_at;
  int          hold_left;
  logic        hold_done;
  int          mismatches;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("utf8_to_utf16le_transcoder: mismatch");
    $finish;
  end

  task automatic push_code(input logic [20:0] cp);
    logic [20:0] d;
    logic [15:0] hi;
    logic [15:0] lo;
    if (cp[20:16] == 5'd0) begin
      step_items.push_back(u8u16_pkg::item_t'{cp[7:0], u8u16_pkg::ST_OK, 1'b0});
      step_items.push_back(u8u16_pkg::item_t'{cp[15:8], u8u16_pkg::ST_OK, 1'b0});
    end else begin
      d  = cp - u8u16_pkg::SUPP_BASE;
      hi = u8u16_pkg::HI_SURR | {5'd0, d[20:10]};
      lo = u8u16_pkg::LO_SURR | {6'd0, d[9:0]};
      step_items.push_back(u8u16_pkg::item_t'{hi[7:0], u8u16_pkg::ST_OK, 1'b0});
      step_items.push_back(u8u16_pkg::item_t'{hi[15:8], u8u16_pkg::ST_OK, 1'b0});
      step_items.push_back(u8u16_pkg::item_t'{lo[7:0], u8u16_pkg::ST_OK, 1'b0});
      step_items.push_back(u8u16_pkg::item_t'{lo[15:8], u8u16_pkg::ST_OK, 1'b0});
    end
  endtask

  task automatic transcode_byte(input logic [7:0] b, input logic fin);
    u8u16_pkg::item_t tail;
    step_items.delete();
    if (string_fresh) begin
      string_fresh = 1'b0;
      if (bom_on) begin
        step_items.push_back(u8u16_pkg::item_t'{u8u16_pkg::BOM_FIRST, u8u16_pkg::ST_OK, 1'b0});
        step_items.push_back(u8u16_pkg::item_t'{u8u16_pkg::BOM_SECOND, u8u16_pkg::ST_OK, 1'b0});
      end
    end
    if (skip_rest) begin
      // dropped up to the end of the string
    end else if (cont_left != 2'd0) begin
      code_pt   = {code_pt[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) push_code(code_pt);
    end else if (!b[7]) begin
      push_code({13'd0, b});
    end else if (b[5:0] < 6'd32) begin
      cont_left = 2'd1;
      code_pt   = {16'd0, b[4:0]};
    end else if (b[5:0] < 6'd48) begin
      cont_left = 2'd2;
      code_pt   = {17'd0, b[3:0]};
    end else if (b[5:0] < 6'd56) begin
      cont_left = 2'd3;
      code_pt   = {18'd0, b[2:0]};
    end else begin
      step_items.push_back(u8u16_pkg::item_t'{8'h00, u8u16_pkg::ST_BAD_LEAD, 1'b1});
      skip_rest = 1'b1;
    end
    if (fin) begin
      if (!skip_rest && cont_left != 2'd0) begin
        step_items.push_back(u8u16_pkg::item_t'{8'h00, u8u16_pkg::ST_TRUNC, 1'b1});
      end else if (step_items.size() != 0) begin
        tail      = step_items.pop_back();
        tail.last = 1'b1;
        step_items.push_back(tail);
      end
      cont_left    = 2'd0;
      code_pt      = 21'd0;
      string_fresh = 1'b1;
      skip_rest    = 1'b0;
    end
    foreach (step_items[i]) pending_utf16.push_back(step_items[i]);
  endtask

  // byte driver
  always @(posedge clk) begin : drive_utf8
    utf8_byte_t nxt;
    if (rst) begin
      utf8_ch.valid <= 1'b0;
    end else begin
      if (utf8_ch.valid && utf8_ch.ready) begin
        transcode_byte(utf8_ch.in_byte, utf8_ch.last_byte);
        accepted_cnt = accepted_cnt + 1;
      end
      if (!utf8_ch.valid || utf8_ch.ready) begin
        if (utf8_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = utf8_q.pop_front();
          utf8_ch.valid     <= 1'b1;
          utf8_ch.in_byte   <= nxt.data;
          utf8_ch.last_byte <= nxt.fin;
        end else begin
          utf8_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && hold_at != 0 && accepted_cnt >= hold_at) begin
      hold_left <= 250;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin : check_utf16
    u8u16_pkg::item_t want;
    if (rst) begin
      utf16_ch.ready <= 1'b0;
    end else begin
      if (utf16_ch.valid && utf16_ch.ready) begin
        if (pending_utf16.size() == 0) begin
          $display("%0t: unexpected transfer, got byte %h status %0d end %0b", $time,
                   utf16_ch.out_byte, utf16_ch.status, utf16_ch.string_end);
          mismatches = mismatches + 1;
        end else begin
          want = pending_utf16.pop_front();
          if (want.data !== utf16_ch.out_byte || want.status !== utf16_ch.status ||
              want.last !== utf16_ch.string_end) begin
            $display("%0t: expected byte %h status %0d end %0b, got byte %h status %0d end %0b",
                     $time, want.data, want.status, want.last,
                     utf16_ch.out_byte, utf16_ch.status, utf16_ch.string_end);
            mismatches = mismatches + 1;
          end
        end
      end
      utf16_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_string(input logic [7:0] s[$]);
    utf8_byte_t e;
    foreach (s[i]) begin
      e.data = s[i];
      e.fin  = (i == s.size() - 1);
      utf8_q.push_back(e);
    end
  endtask

  task automatic queue_directed(input logic [63:0] seq, input int len);
    logic [7:0] s[$];
    for (int i = len - 1; i >= 0; i--) s.push_back(seq[8*i +: 8]);
    queue_string(s);
  endtask

  task automatic queue_random(input int target);
    logic [7:0] s[$];
    logic [7:0] b;
    int added;
    int n_cp;
    int sel;
    int need;
    int keep;
    added = 0;
    while (added < target) begin
      s.delete();
      n_cp = $urandom_range(6, 1);
      for (int i = 0; i < n_cp; i++) begin
        sel = $urandom_range(99);
        if (sel < 8) begin
          s.push_back(8'($urandom_range(255)));
        end else if (sel < 35) begin
          s.push_back(8'($urandom_range(127)));
        end else if (sel < 92) begin
          need = (sel < 58) ? 1 : (sel < 78) ? 2 : 3;
          if (need == 1) b[5:0] = 6'($urandom_range(31));
          else if (need == 2) b[5:0] = 6'($urandom_range(47, 32));
          else b[5:0] = 6'($urandom_range(55, 48));
          b[7:6] = $urandom_range(1) ? 2'b11 : 2'b10;
          s.push_back(b);
          // sometimes cut the final sequence short
          keep = (i == n_cp - 1 && $urandom_range(7) == 0) ? $urandom_range(need - 1) : need;
          repeat (keep) begin
            if ($urandom_range(7) == 0) s.push_back(8'($urandom_range(255)));
            else s.push_back({2'b10, 6'($urandom_range(63))});
          end
        end else begin
          b = {($urandom_range(1) ? 2'b11 : 2'b10), 3'b111, 3'($urandom_range(7))};
          s.push_back(b);
          repeat ($urandom_range(3)) s.push_back(8'($urandom_range(255)));
        end
      end
      queue_string(s);
      added += s.size();
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (utf8_q.size() != 0 || utf8_ch.valid || pending_utf16.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_bom(input logic v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    bom_on = v;
  endtask

  initial begin : stimulus
    rst               = 1'b1;
    utf8_ch.valid     = 1'b0;
    utf8_ch.in_byte   = 8'h00;
    utf8_ch.last_byte = 1'b0;
    utf16_ch.ready    = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = 1'b0;
    bom_on            = 1'b1;
    cont_left         = 2'd0;
    code_pt           = 21'd0;
    string_fresh      = 1'b1;
    skip_rest         = 1'b0;
    accepted_cnt      = 0;
    hold_at           = 0;
    mismatches        = 0;
    send_idle_pct     = 17;
    recv_idle_pct     = 82;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    queue_directed(64'h00, 1);
    queue_directed(64'h7F, 1);
    queue_directed(64'hC3A9, 2);
    queue_directed(64'hE282AC, 3);
    queue_directed(64'hF09F9880, 4);
    queue_directed(64'hF7BFBFBF, 4);        // largest code point
    queue_directed(64'h80FF, 2);            // low lead range, unchecked continuation
    queue_directed(64'hFF4142, 3);          // bad lead, rest dropped
    queue_directed(64'hB8, 1);              // bad lead on the last byte
    queue_directed(64'hB780, 2);            // truncated
    queue_directed(64'hC0, 1);              // truncated on the first byte
    queue_random(120);
    wait_drained();

    write_bom(1'b0);
    send_idle_pct = 82;
    recv_idle_pct = 17;
    queue_random(150);
    wait_drained();

    write_bom(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_at       = accepted_cnt + 40;
    queue_random(160);
    wait_drained();

    repeat (12) @(posedge clk);
    if (pending_utf16.size() != 0) begin
      $display("%0t: %0d expected transfers never arrived", $time, pending_utf16.size());
      mismatches = mismatches + 1;
    end
    if (mismatches == 0) begin
      $display("utf8_to_utf16le_transcoder: match");
    end else begin
      $display("utf8_to_utf16le_transcoder: mismatch");
    end
    $finish;
  end

endmodule
